/* rtl/core/guillotine_free_rect_select_split_core_assert.svh */
// ---------------------------------------------------------------------------
// guillotine free rectangle core: assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef GUILLOTINE_FREE_RECT_SELECT_SPLIT_CORE_ASSERT_SVH
`define GUILLOTINE_FREE_RECT_SELECT_SPLIT_CORE_ASSERT_SVH

// same-cycle implication
`define GFRSS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gfrss: same-cycle check failed");

// next-cycle implication
`define GFRSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gfrss: next-cycle check failed");

`endif

/* rtl/core/gfrss_pkg.sv */
// ---------------------------------------------------------------------------
// gfrss_pkg
// constants, codes, types and helpers of the free rectangle core
// ---------------------------------------------------------------------------
`default_nettype none

package gfrss_pkg;

   localparam int MAX_ENTRIES    = 64;
   localparam int COORD_BITS     = 16;
   localparam int FIELD_BITS     = 16;
   localparam int IDX_FIELD_BITS = 6;
   localparam int IDX_BITS       = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS       = $clog2(MAX_ENTRIES + 1);
   localparam int ENTRY_BITS     = 4 * COORD_BITS;
   localparam int SCORE_BITS     = 2 * COORD_BITS;

   // item kinds
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // fit heuristics
   localparam logic [1:0] FIT_AREA  = 2'd0;
   localparam logic [1:0] FIT_SHORT = 2'd1;
   localparam logic [1:0] FIT_LONG  = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } rect_type;

   localparam rect_type RECT_NONE = '0;

   typedef struct packed {
      logic [1:0]                status;
      logic [IDX_FIELD_BITS-1:0] chosen_index;
      logic                      rect_valid;
      logic [FIELD_BITS-1:0]     out_x;
      logic [FIELD_BITS-1:0]     out_y;
      logic [FIELD_BITS-1:0]     out_w;
      logic [FIELD_BITS-1:0]     out_h;
      logic                      last;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic take_clear;
      logic take_append;
      logic take_query;
      logic scan_rd;
      logic do_split;
      logic load_first;
      logic load_second;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic two_results;
      logic out_free;
   } dp_stat_type;

   function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
   endfunction

   function automatic result_type make_result(input logic [1:0]                status,
                                              input logic [IDX_FIELD_BITS-1:0] idx,
                                              input logic                      valid,
                                              input rect_type                  r,
                                              input logic                      last);
      result_type res;
      res.status       = status;
      res.chosen_index = idx;
      res.rect_valid   = valid;
      res.out_x        = valid ? FIELD_BITS'(r.x) : '0;
      res.out_y        = valid ? FIELD_BITS'(r.y) : '0;
      res.out_w        = valid ? FIELD_BITS'(r.w) : '0;
      res.out_h        = valid ? FIELD_BITS'(r.h) : '0;
      res.last         = last;
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gfrss_req_if.sv */
// ---------------------------------------------------------------------------
// gfrss_req_if
// request channel: clear, append or query items
// ---------------------------------------------------------------------------
`default_nettype none

interface gfrss_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic [gfrss_pkg::FIELD_BITS-1:0] pos_x;
   logic [gfrss_pkg::FIELD_BITS-1:0] pos_y;
   logic [gfrss_pkg::FIELD_BITS-1:0] size_w;
   logic [gfrss_pkg::FIELD_BITS-1:0] size_h;

   modport source (output valid, kind, pos_x, pos_y, size_w, size_h, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, size_w, size_h, output ready);
endinterface

`default_nettype wire

/* rtl/core/gfrss_rsp_if.sv */
// ---------------------------------------------------------------------------
// gfrss_rsp_if
// response channel: status, chosen index and leftover rectangles
// ---------------------------------------------------------------------------
`default_nettype none

interface gfrss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [gfrss_pkg::IDX_FIELD_BITS-1:0] chosen_index;
   logic                                rect_valid;
   logic [gfrss_pkg::FIELD_BITS-1:0]     out_x;
   logic [gfrss_pkg::FIELD_BITS-1:0]     out_y;
   logic [gfrss_pkg::FIELD_BITS-1:0]     out_w;
   logic [gfrss_pkg::FIELD_BITS-1:0]     out_h;
   logic                                last;

   modport source (output valid, status, chosen_index, rect_valid, out_x, out_y, out_w,
                   out_h, last, input ready);
   modport sink   (input valid, status, chosen_index, rect_valid, out_x, out_y, out_w,
                   out_h, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/gfrss_ram.sv */
// ---------------------------------------------------------------------------
// gfrss_ram
// generic one-write one-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module gfrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/gfrss_ctrl.sv */
// ---------------------------------------------------------------------------
// gfrss_ctrl
// item sequencer: accept, scan, split and result hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module gfrss_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [1:0]             req_kind,
   output logic                        req_ready,
   input  wire gfrss_pkg::dp_stat_type stat,
   output gfrss_pkg::dp_cmd_type       cmd
);

   import gfrss_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SPLIT = 3'd3;
   localparam logic [2:0] ST_EMIT1 = 3'd4;
   localparam logic [2:0] ST_EMIT2 = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_CLEAR: begin
                     cmd.take_clear = 1'b1;
                     state_in       = ST_EMIT1;
                  end
                  KIND_APPEND: begin
                     cmd.take_append = 1'b1;
                     state_in        = ST_EMIT1;
                  end
                  KIND_QUERY: begin
                     cmd.take_query = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: ;  // unused kind, dropped
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            cmd.do_split = 1'b1;
            state_in     = ST_EMIT1;
         end
         ST_EMIT1: begin
            if (stat.out_free) begin
               cmd.load_first = 1'b1;
               state_in       = stat.two_results ? ST_EMIT2 : ST_IDLE;
            end
         end
         ST_EMIT2: begin
            if (stat.out_free) begin
               cmd.load_second = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/gfrss_dp.sv */
// ---------------------------------------------------------------------------
// gfrss_dp
// table count, scan pipeline, best-fit tracking, split and output register
// ---------------------------------------------------------------------------
`default_nettype none

module gfrss_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gfrss_pkg::dp_cmd_type              cmd,
   output gfrss_pkg::dp_stat_type                  stat,
   input  wire logic [gfrss_pkg::FIELD_BITS-1:0]   req_pos_x,
   input  wire logic [gfrss_pkg::FIELD_BITS-1:0]   req_pos_y,
   input  wire logic [gfrss_pkg::FIELD_BITS-1:0]   req_size_w,
   input  wire logic [gfrss_pkg::FIELD_BITS-1:0]   req_size_h,
   input  wire logic                               csr_we,
   input  wire logic [1:0]                         csr_wdata,
   output logic                                    ram_wr_en,
   output logic [gfrss_pkg::IDX_BITS-1:0]          ram_wr_addr,
   output logic [gfrss_pkg::ENTRY_BITS-1:0]        ram_wr_data,
   output logic                                    ram_rd_en,
   output logic [gfrss_pkg::IDX_BITS-1:0]          ram_rd_addr,
   input  wire logic [gfrss_pkg::ENTRY_BITS-1:0]   ram_rd_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output gfrss_pkg::result_type                   rsp_data
);

   import gfrss_pkg::*;

   logic [1:0]            heuristic_ff;
   logic [CNT_BITS-1:0]   entry_count_ff;
   logic                  table_full;
   logic [COORD_BITS-1:0] req_w_ff;
   logic [COORD_BITS-1:0] req_h_ff;
   logic [CNT_BITS-1:0]   scan_idx_ff;

   // read stage
   logic                  rd_pend_ff;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   rect_type              rd_rect;
   logic                  rd_fit;
   logic [COORD_BITS-1:0] rd_dw;
   logic [COORD_BITS-1:0] rd_dh;
   logic [SCORE_BITS-1:0] rd_area;
   logic [SCORE_BITS-1:0] rd_score;

   // score stage
   logic                  sc_vld_ff;
   logic [SCORE_BITS-1:0] sc_score_ff;
   rect_type              sc_rect_ff;
   logic [IDX_BITS-1:0]   sc_idx_ff;

   // best so far
   logic                  found_ff;
   logic [SCORE_BITS-1:0] best_score_ff;
   rect_type              best_rect_ff;
   logic [IDX_BITS-1:0]   best_idx_ff;

   // split and staged results
   logic [COORD_BITS-1:0]     sp_dw;
   logic [COORD_BITS-1:0]     sp_dh;
   logic [COORD_BITS-1:0]     sp_xs;
   logic [COORD_BITS-1:0]     sp_ys;
   logic [IDX_FIELD_BITS-1:0] sp_idx;
   result_type                res1_ff;
   result_type                res1_in;
   result_type                res2_ff;
   result_type                res2_in;
   logic                      two_ff;
   logic                      two_in;
   logic                      out_vld_ff;
   result_type                out_ff;

   assign table_full = (entry_count_ff >= CNT_BITS'(MAX_ENTRIES));

   // append writes straight from the request payload
   assign ram_wr_en   = cmd.take_append && !table_full;
   assign ram_wr_addr = entry_count_ff[IDX_BITS-1:0];
   assign ram_wr_data = {COORD_BITS'(req_pos_x), COORD_BITS'(req_pos_y),
                         COORD_BITS'(req_size_w), COORD_BITS'(req_size_h)};
   assign ram_rd_en   = cmd.scan_rd;
   assign ram_rd_addr = scan_idx_ff[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         heuristic_ff   <= FIT_AREA;
         entry_count_ff <= '0;
         scan_idx_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         sc_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
         two_ff         <= 1'b0;
         out_vld_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            heuristic_ff <= csr_wdata;
         end
         if (cmd.take_clear) begin
            entry_count_ff <= '0;
         end else if (ram_wr_en) begin
            entry_count_ff <= entry_count_ff + CNT_BITS'(1);
         end
         if (cmd.take_query) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_rd) begin
            scan_idx_ff <= scan_idx_ff + CNT_BITS'(1);
         end
         rd_pend_ff <= cmd.scan_rd;
         sc_vld_ff  <= rd_pend_ff && rd_fit;
         if (cmd.take_query) begin
            found_ff <= 1'b0;
         end else if (sc_vld_ff && (!found_ff || sc_score_ff < best_score_ff)) begin
            found_ff <= 1'b1;
         end
         two_ff <= two_in;
         if (cmd.load_first || cmd.load_second) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // score of the entry just read
   assign rd_rect = rect_type'(ram_rd_data);
   assign rd_fit  = (rd_rect.w >= req_w_ff) && (rd_rect.h >= req_h_ff);
   assign rd_dw   = rd_rect.w - req_w_ff;
   assign rd_dh   = rd_rect.h - req_h_ff;
   assign rd_area = rd_rect.w * rd_rect.h;

   always_comb begin
      unique case (heuristic_ff)
         FIT_SHORT: rd_score = SCORE_BITS'((rd_dw < rd_dh) ? rd_dw : rd_dh);
         FIT_LONG:  rd_score = SCORE_BITS'((rd_dw > rd_dh) ? rd_dw : rd_dh);
         default:   rd_score = rd_area;  // area fit, also for the unused code
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.take_query) begin
         req_w_ff <= COORD_BITS'(req_size_w);
         req_h_ff <= COORD_BITS'(req_size_h);
      end
      rd_idx_ff   <= scan_idx_ff[IDX_BITS-1:0];
      sc_score_ff <= rd_score;
      sc_rect_ff  <= rd_rect;
      sc_idx_ff   <= rd_idx_ff;
      // strict less keeps the first of equal scores
      if (sc_vld_ff && (!found_ff || sc_score_ff < best_score_ff)) begin
         best_score_ff <= sc_score_ff;
         best_rect_ff  <= sc_rect_ff;
         best_idx_ff   <= sc_idx_ff;
      end
      res1_ff <= res1_in;
      res2_ff <= res2_in;
      if (cmd.load_first) begin
         out_ff <= res1_ff;
      end else if (cmd.load_second) begin
         out_ff <= res2_ff;
      end
   end

   // guillotine split of the chosen entry
   assign sp_dw  = best_rect_ff.w - req_w_ff;
   assign sp_dh  = best_rect_ff.h - req_h_ff;
   assign sp_xs  = sat_add(best_rect_ff.x, req_w_ff);
   assign sp_ys  = sat_add(best_rect_ff.y, req_h_ff);
   assign sp_idx = IDX_FIELD_BITS'(best_idx_ff);

   always_comb begin
      res1_in = res1_ff;
      res2_in = res2_ff;
      two_in  = two_ff;
      priority if (cmd.take_clear) begin
         res1_in = make_result(STATUS_OK, '0, 1'b0, RECT_NONE, 1'b1);
         two_in  = 1'b0;
      end else if (cmd.take_append) begin
         res1_in = make_result(table_full ? STATUS_FULL : STATUS_OK, '0, 1'b0, RECT_NONE,
                               1'b1);
         two_in  = 1'b0;
      end else if (cmd.do_split) begin
         two_in = 1'b0;
         priority if (!found_ff) begin
            res1_in = make_result(STATUS_NO_FIT, '0, 1'b0, RECT_NONE, 1'b1);
         end else if (sp_dw != '0 && sp_dh != '0) begin
            two_in = 1'b1;
            if (sp_dw > sp_dh) begin
               res1_in = make_result(STATUS_OK, sp_idx, 1'b1,
                                     '{sp_xs, best_rect_ff.y, sp_dw, best_rect_ff.h}, 1'b0);
               res2_in = make_result(STATUS_OK, sp_idx, 1'b1,
                                     '{best_rect_ff.x, sp_ys, req_w_ff, sp_dh}, 1'b1);
            end else begin
               res1_in = make_result(STATUS_OK, sp_idx, 1'b1,
                                     '{best_rect_ff.x, sp_ys, best_rect_ff.w, sp_dh}, 1'b0);
               res2_in = make_result(STATUS_OK, sp_idx, 1'b1,
                                     '{sp_xs, best_rect_ff.y, sp_dw, req_h_ff}, 1'b1);
            end
         end else if (sp_dw != '0) begin
            res1_in = make_result(STATUS_OK, sp_idx, 1'b1,
                                  '{sp_xs, best_rect_ff.y, sp_dw, best_rect_ff.h}, 1'b1);
         end else if (sp_dh != '0) begin
            res1_in = make_result(STATUS_OK, sp_idx, 1'b1,
                                  '{best_rect_ff.x, sp_ys, best_rect_ff.w, sp_dh}, 1'b1);
         end else begin
            res1_in = make_result(STATUS_OK, sp_idx, 1'b0, RECT_NONE, 1'b1);
         end
      end
   end

   assign stat.scan_done   = (scan_idx_ff == entry_count_ff);
   assign stat.two_results = two_ff;
   assign stat.out_free    = !out_vld_ff || rsp_ready;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

/* rtl/core/guillotine_free_rect_select_split_core.sv */
// ---------------------------------------------------------------------------
// guillotine_free_rect_select_split_core
// free rectangle table with best-fit query and guillotine split
// ---------------------------------------------------------------------------
//
//   channel   direction  transfer when         carries
//   req_chan  in         valid & ready         kind, pos_x, pos_y, size_w, size_h
//   rsp_chan  out        valid & ready         status, chosen_index, rect_valid,
//                                              out_x, out_y, out_w, out_h, last
//   csr_*     in         csr_we                fit_heuristic (2 bits)
//
// clear and append finish at the request transfer, their result is staged in a result
//    register and then loaded into the output register once that register is free
// a query scans all stored entries, reading one table entry per cycle from the
//    single ram read port, then finishes the read and score stages, the best-fit
//    compare and the split before its first result is loaded into the output register
// the block is busy from the request transfer until the item's last result has moved
//    into the output register, which waits while its held result stalls on rsp ready
// reset is synchronous: entry count, heuristic and control clear, table words are
//    left as they are and only read once rewritten
// a waiting result sits in the output register; the next request is taken as soon as
//    the previous item's last result has moved into that register
//
`default_nettype none

module guillotine_free_rect_select_split_core (
   input  wire logic       clock,
   input  wire logic       reset,
   gfrss_req_if.sink       req_chan,
   gfrss_rsp_if.source     rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_wdata
);

   import gfrss_pkg::*;

   // controller / datapath handshake
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // table ram ports
   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   // output register contents
   logic       rsp_valid;
   result_type rsp_data;

   // sequencer: decides kind, steps the scan, hands results to the output register
   gfrss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: count, scan pipeline, best tracking, split, output register
   gfrss_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_pos_x   (req_chan.pos_x),
      .req_pos_y   (req_chan.pos_y),
      .req_size_w  (req_chan.size_w),
      .req_size_h  (req_chan.size_h),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_data    (rsp_data)
   );

   // free rectangle table, one entry {x, y, w, h} per word
   gfrss_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result fields onto the response channel
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.status       = rsp_data.status;
   assign rsp_chan.chosen_index = rsp_data.chosen_index;
   assign rsp_chan.rect_valid   = rsp_data.rect_valid;
   assign rsp_chan.out_x        = rsp_data.out_x;
   assign rsp_chan.out_y        = rsp_data.out_y;
   assign rsp_chan.out_w        = rsp_data.out_w;
   assign rsp_chan.out_h        = rsp_data.out_h;
   assign rsp_chan.last         = rsp_data.last;

endmodule

`default_nettype wire

/* rtl/core/gfrss_chk.sv */
// ---------------------------------------------------------------------------
// gfrss_chk
// port-level checks of the free rectangle core, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "guillotine_free_rect_select_split_core_assert.svh"

module gfrss_chk (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [1:0]                           rsp_status,
   input wire logic [gfrss_pkg::IDX_FIELD_BITS-1:0] rsp_chosen_index,
   input wire logic                                 rsp_rect_valid,
   input wire logic [gfrss_pkg::FIELD_BITS-1:0]     rsp_out_x,
   input wire logic [gfrss_pkg::FIELD_BITS-1:0]     rsp_out_y,
   input wire logic [gfrss_pkg::FIELD_BITS-1:0]     rsp_out_w,
   input wire logic [gfrss_pkg::FIELD_BITS-1:0]     rsp_out_h,
   input wire logic                                 rsp_last
);

   import gfrss_pkg::*;

   logic [4*FIELD_BITS-1:0] rect_bits;
   logic [4*FIELD_BITS+IDX_FIELD_BITS+3:0] payload;

   assign rect_bits = {rsp_out_x, rsp_out_y, rsp_out_w, rsp_out_h};
   assign payload   = {rsp_status, rsp_chosen_index, rsp_rect_valid, rect_bits, rsp_last};

   // a stalled result keeps its value
   `GFRSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(payload))

   // no leftover rectangle means all rectangle fields are zero
   `GFRSS_ASSERT_NOW(a_empty_rect, clock, reset, rsp_valid && !rsp_rect_valid, rect_bits == '0)

   // a failed item gives one bare result
   `GFRSS_ASSERT_NOW(a_fail_single, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_last && !rsp_rect_valid && rsp_chosen_index == '0)

   // the second split rectangle is still owed, so no new request is taken
   `GFRSS_ASSERT_NOW(a_pair_blocks, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // nothing is shown right after reset
   `GFRSS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind guillotine_free_rect_select_split_core gfrss_chk u_gfrss_chk (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_chosen_index (rsp_chan.chosen_index),
   .rsp_rect_valid   (rsp_chan.rect_valid),
   .rsp_out_x        (rsp_chan.out_x),
   .rsp_out_y        (rsp_chan.out_y),
   .rsp_out_w        (rsp_chan.out_w),
   .rsp_out_h        (rsp_chan.out_h),
   .rsp_last         (rsp_chan.last)
);

`default_nettype wire

/* tb/sv/guillotine_free_rect_select_split_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// guillotine_free_rect_select_split_core_tb
// self-checking bench for the free rectangle table: a software copy of the
// table predicts every result of clear, append and query transfers under
// each fit heuristic, with random idling and back-pressure on both channels
// ---------------------------------------------------------------------------

module guillotine_free_rect_select_split_core_tb;
   import gfrss_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] KIND_UNUSED     = 2'd3;
   localparam logic [1:0] FIT_UNUSED_AREA = 2'd3;

   // a query scans up to 64 entries plus split and emit; the quiet wait outlasts it
   localparam int QUIET_CYCLES = 80;
   localparam int DRAIN_LIMIT  = 20000;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_wdata;

   gfrss_req_if req_chan ();
   gfrss_rsp_if rsp_chan ();

   guillotine_free_rect_select_split_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // software copy of the block state
   rect_type   table_rects [MAX_ENTRIES];
   int         table_count = 0;
   logic [1:0] fit_mode    = FIT_AREA;

   // results still owed by the block, oldest first
   result_type placement_queue [$];

   int error_count = 0;
   int items_sent  = 0;

   // idling controls for the sender and the result receiver
   bit req_idle_enable  = 1'b1;
   bit rsp_stall_enable = 1'b1;
   int rsp_hold_cycles  = 0;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic logic [15:0] clamp_sum(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // score of one fitting entry, lower wins; unused heuristic falls back to area
   function automatic longint unsigned fit_score(input rect_type e, input logic [15:0] rw,
                                                 input logic [15:0] rh);
      logic [15:0] dw;
      logic [15:0] dh;
      dw = e.w - rw;
      dh = e.h - rh;
      case (fit_mode)
         FIT_SHORT: return 64'((dw < dh) ? dw : dh);
         FIT_LONG:  return 64'((dw > dh) ? dw : dh);
         default:   return 64'(e.w) * 64'(e.h);
      endcase
   endfunction

   function automatic void push_placement(input logic [1:0] status, input logic [5:0] idx,
                                          input logic valid, input rect_type r,
                                          input logic fin);
      result_type res;
      res.status       = status;
      res.chosen_index = idx;
      res.rect_valid   = valid;
      res.out_x        = valid ? r.x : 16'h0;
      res.out_y        = valid ? r.y : 16'h0;
      res.out_w        = valid ? r.w : 16'h0;
      res.out_h        = valid ? r.h : 16'h0;
      res.last         = fin;
      placement_queue  = {placement_queue, res};
   endfunction

   // applies one accepted request to the table copy and queues its results
   function automatic void select_and_split(input logic [1:0] kind, input logic [15:0] px,
                                            input logic [15:0] py, input logic [15:0] rw,
                                            input logic [15:0] rh);
      bit              found;
      int              best_i;
      longint unsigned best_s;
      longint unsigned s;
      rect_type        b;
      rect_type        r1;
      rect_type        r2;
      logic [15:0]     dw;
      logic [15:0]     dh;
      logic [5:0]      idx;
      found  = 1'b0;
      best_i = 0;
      best_s = 0;
      case (kind)
         KIND_CLEAR: begin
            table_count = 0;
            push_placement(STATUS_OK, 6'd0, 1'b0, RECT_NONE, 1'b1);
         end
         KIND_APPEND: begin
            if (table_count >= MAX_ENTRIES) begin
               push_placement(STATUS_FULL, 6'd0, 1'b0, RECT_NONE, 1'b1);
            end else begin
               table_rects[table_count].x = px;
               table_rects[table_count].y = py;
               table_rects[table_count].w = rw;
               table_rects[table_count].h = rh;
               table_count++;
               push_placement(STATUS_OK, 6'd0, 1'b0, RECT_NONE, 1'b1);
            end
         end
         KIND_QUERY: begin
            for (int i = 0; i < table_count; i++) begin
               if (table_rects[i].w >= rw && table_rects[i].h >= rh) begin
                  s = fit_score(table_rects[i], rw, rh);
                  // strict compare keeps the lowest index on ties
                  if (!found || s < best_s) begin
                     found  = 1'b1;
                     best_s = s;
                     best_i = i;
                  end
               end
            end
            if (!found) begin
               push_placement(STATUS_NO_FIT, 6'd0, 1'b0, RECT_NONE, 1'b1);
            end else begin
               b   = table_rects[best_i];
               idx = best_i[5:0];
               dw  = b.w - rw;
               dh  = b.h - rh;
               if (dw != 0 && dh != 0) begin
                  if (dw > dh) begin
                     r1.x = clamp_sum(b.x, rw); r1.y = b.y; r1.w = dw; r1.h = b.h;
                     r2.x = b.x; r2.y = clamp_sum(b.y, rh); r2.w = rw; r2.h = dh;
                  end else begin
                     r1.x = b.x; r1.y = clamp_sum(b.y, rh); r1.w = b.w; r1.h = dh;
                     r2.x = clamp_sum(b.x, rw); r2.y = b.y; r2.w = dw; r2.h = rh;
                  end
                  push_placement(STATUS_OK, idx, 1'b1, r1, 1'b0);
                  push_placement(STATUS_OK, idx, 1'b1, r2, 1'b1);
               end else if (dw != 0) begin
                  r1.x = clamp_sum(b.x, rw); r1.y = b.y; r1.w = dw; r1.h = b.h;
                  push_placement(STATUS_OK, idx, 1'b1, r1, 1'b1);
               end else if (dh != 0) begin
                  r1.x = b.x; r1.y = clamp_sum(b.y, rh); r1.w = b.w; r1.h = dh;
                  push_placement(STATUS_OK, idx, 1'b1, r1, 1'b1);
               end else begin
                  push_placement(STATUS_OK, idx, 1'b0, RECT_NONE, 1'b1);
               end
            end
         end
         default: ; // unused kind is dropped by the block
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // random helpers
   // ------------------------------------------------------------------------

   // mostly back-to-back, often a few cycles, now and then a long gap
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // coordinate biased toward zero, small values and the top of the range
   function automatic logic [15:0] random_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(65500, 65535));
         3, 4, 5: return 16'($urandom_range(0, 64));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // requested side derived from a stored side: exact, a bit less, anything less,
   // or one more so that this entry stops fitting
   function automatic logic [15:0] shrink_side(input logic [15:0] v);
      int r;
      r = $urandom_range(0, 5);
      case (r)
         0, 1:    return v;
         2:       return (v > 8) ? v - 16'($urandom_range(1, 8)) : 16'h0;
         3, 4:    return 16'($urandom_range(0, v));
         default: return (v == 16'hFFFF) ? v : v + 16'd1;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   task automatic send_item(input logic [1:0] kind, input logic [15:0] px,
                            input logic [15:0] py, input logic [15:0] rw,
                            input logic [15:0] rh);
      int gap;
      gap = req_idle_enable ? idle_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.kind   <= kind;
      req_chan.pos_x  <= px;
      req_chan.pos_y  <= py;
      req_chan.size_w <= rw;
      req_chan.size_h <= rh;
      do @(posedge clock); while (!req_chan.ready);
      select_and_split(kind, px, py, rw, rh);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic send_append();
      int i;
      if (table_count > 0 && $urandom_range(0, 7) == 0) begin
         // same size as an earlier entry, for score ties
         i = $urandom_range(0, table_count - 1);
         send_item(KIND_APPEND, random_coord(), random_coord(),
                   table_rects[i].w, table_rects[i].h);
      end else begin
         send_item(KIND_APPEND, random_coord(), random_coord(), random_coord(),
                   random_coord());
      end
   endtask

   task automatic send_query();
      int i;
      if (table_count > 0 && $urandom_range(0, 4) != 0) begin
         i = $urandom_range(0, table_count - 1);
         send_item(KIND_QUERY, random_coord(), random_coord(),
                   shrink_side(table_rects[i].w), shrink_side(table_rects[i].h));
      end else begin
         send_item(KIND_QUERY, random_coord(), random_coord(), random_coord(),
                   random_coord());
      end
   endtask

   task automatic send_noise_item();
      logic [1:0] kind;
      kind = ($urandom_range(0, 2) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 3));
      send_item(kind, random_coord(), random_coord(), random_coord(), random_coord());
   endtask

   // lower valid and wait until the block has returned everything owed
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (placement_queue.size() != 0) @(posedge clock);
   endtask

   // heuristic changes only while the block is idle; after the owed results are
   // back, let the longest scan pass as well
   task automatic write_fit_heuristic(input logic [1:0] mode);
      wait_for_results();
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      fit_mode = mode;
      csr_we   <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   // random stalls, plus a long hold whenever a test asks for one
   initial begin : rsp_ready_drive
      int stall;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_chan.ready <= 1'b1;
         end else if (rsp_stall_enable && $urandom_range(0, 2) == 0) begin
            stall = 1 + idle_gap();
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("[%0t] result mismatch on %s: got %h, want %h", $realtime, field, got, want);
      error_count++;
   endtask

   // every transfer on the result channel is checked against the oldest owed result
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (placement_queue.size() == 0) begin
            report_mismatch("transfer with nothing owed", 16'h0, 16'h0);
         end else begin
            want = placement_queue.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 16'(rsp_chan.status), 16'(want.status));
            if (rsp_chan.chosen_index !== want.chosen_index)
               report_mismatch("chosen_index", 16'(rsp_chan.chosen_index),
                               16'(want.chosen_index));
            if (rsp_chan.rect_valid !== want.rect_valid)
               report_mismatch("rect_valid", 16'(rsp_chan.rect_valid), 16'(want.rect_valid));
            if (rsp_chan.out_x !== want.out_x)
               report_mismatch("out_x", rsp_chan.out_x, want.out_x);
            if (rsp_chan.out_y !== want.out_y)
               report_mismatch("out_y", rsp_chan.out_y, want.out_y);
            if (rsp_chan.out_w !== want.out_w)
               report_mismatch("out_w", rsp_chan.out_w, want.out_w);
            if (rsp_chan.out_h !== want.out_h)
               report_mismatch("out_h", rsp_chan.out_h, want.out_h);
            if (rsp_chan.last !== want.last)
               report_mismatch("last", 16'(rsp_chan.last), 16'(want.last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // random packing rounds: mostly clear, a run of appends, then queries,
   // with some noise transfers mixed in
   task automatic run_packing_rounds(input int item_budget);
      int stop_at;
      int n_app;
      int n_qry;
      stop_at = items_sent + item_budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            send_noise_item();
         end else begin
            if ($urandom_range(0, 3) != 0)
               send_item(KIND_CLEAR, random_coord(), random_coord(), random_coord(),
                         random_coord());
            // an occasional long run may overflow the table
            n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                                : $urandom_range(1, 10);
            repeat (n_app) send_append();
            n_qry = $urandom_range(1, 6);
            repeat (n_qry) begin
               send_query();
               if ($urandom_range(0, 7) == 0) send_append();
            end
         end
      end
   endtask

   task automatic test_directed_cases();
      // empty table, clear on empty
      send_item(KIND_QUERY, 16'h0, 16'h0, 16'h0, 16'h0);
      send_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // one entry: exact fit, width-only, height-only and two-way splits
      send_item(KIND_APPEND, 16'd0, 16'd0, 16'd100, 16'd50);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd100, 16'd50);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd40, 16'd50);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd100, 16'd20);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd40, 16'd20);
      // second entry wins on area, split along the height
      send_item(KIND_APPEND, 16'd10, 16'd10, 16'd30, 16'd80);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd10, 16'd20);
      // nothing fits
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd200, 16'd10);
      // sums saturate near the top of the coordinate range
      send_item(KIND_APPEND, 16'hFFFA, 16'hFFFC, 16'd30, 16'd40);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd10, 16'd10);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd25, 16'd10);
      // full-size entry and a zero-size entry
      send_item(KIND_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_QUERY, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF);
      send_item(KIND_QUERY, 16'h0, 16'h0, 16'h0001, 16'hFFFF);
      send_item(KIND_APPEND, 16'h0, 16'h0, 16'h0, 16'h0);
      send_item(KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0);
      // unused kind is dropped, with all field bits both ways
      send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_UNUSED, 16'h0, 16'h0, 16'h0, 16'h0);
      // equal scores resolve to the lower index
      send_item(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0);
      send_item(KIND_APPEND, 16'd5, 16'd5, 16'd10, 16'd10);
      send_item(KIND_APPEND, 16'd50, 16'd50, 16'd10, 16'd10);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd5, 16'd5);
   endtask

   task automatic test_full_table();
      send_item(KIND_CLEAR, random_coord(), random_coord(), random_coord(), random_coord());
      repeat (MAX_ENTRIES - 1)
         send_item(KIND_APPEND, random_coord(), random_coord(),
                   16'($urandom_range(1000, 2000)), 16'($urandom_range(1000, 2000)));
      // smallest entry sits at the top index
      send_item(KIND_APPEND, 16'd7, 16'd9, 16'd50, 16'd50);
      send_item(KIND_APPEND, 16'd1, 16'd1, 16'd1, 16'd1);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd40, 16'd40);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd900, 16'd900);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd3000, 16'd1);
      send_item(KIND_CLEAR, random_coord(), random_coord(), random_coord(), random_coord());
      send_item(KIND_APPEND, 16'd3, 16'd4, 16'd20, 16'd20);
      send_item(KIND_QUERY, 16'd0, 16'd0, 16'd20, 16'd10);
   endtask

   task automatic test_fit_heuristics();
      logic [1:0] modes [4];
      modes = '{FIT_SHORT, FIT_LONG, FIT_UNUSED_AREA, FIT_AREA};
      foreach (modes[m]) begin
         write_fit_heuristic(modes[m]);
         // area and long side pick the square, short side picks the strip
         send_item(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0);
         send_item(KIND_APPEND, 16'd0, 16'd0, 16'd100, 16'd10);
         send_item(KIND_APPEND, 16'd0, 16'd0, 16'd30, 16'd30);
         send_item(KIND_QUERY, 16'd0, 16'd0, 16'd20, 16'd5);
         run_packing_rounds(170);
      end
   endtask

   task automatic test_back_to_back();
      wait_for_results();
      req_idle_enable  = 1'b0;
      rsp_stall_enable = 1'b0;
      run_packing_rounds(100);
      req_idle_enable  = 1'b1;
      rsp_stall_enable = 1'b1;
   endtask

   // receiver holds off long enough that the block backs up into its input
   task automatic test_output_backpressure();
      rsp_hold_cycles = 400;
      send_item(KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0);
      repeat (6) send_append();
      repeat (12) send_query();
      run_packing_rounds(15);
   endtask

   // sender stops until every owed result is back, then carries on
   task automatic test_sender_pause();
      run_packing_rounds(20);
      wait_for_results();
      repeat (4) send_query();
      run_packing_rounds(20);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------

   initial begin : main_sequence
      int waited;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= FIT_AREA;
      req_chan.valid  <= 1'b0;
      req_chan.kind   <= KIND_CLEAR;
      req_chan.pos_x  <= 16'h0;
      req_chan.pos_y  <= 16'h0;
      req_chan.size_w <= 16'h0;
      req_chan.size_h <= 16'h0;
      rsp_chan.ready  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_full_table();
      test_fit_heuristics();
      test_back_to_back();
      test_output_backpressure();
      test_sender_pause();

      // drain whatever is still owed, then let the block settle
      req_chan.valid <= 1'b0;
      waited = 0;
      while (placement_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
      if (placement_queue.size() != 0)
         report_mismatch("results never returned", 16'(placement_queue.size()), 16'h0);

      if (error_count == 0) begin
         $display("guillotine_free_rect_select_split_core regression: pass");
      end else begin
         $display("guillotine_free_rect_select_split_core regression: fail");
      end
      $finish;
   end

   // run limit, several times the slowest correct run
   initial begin : run_limit
      #10_000_000;
      $display("guillotine_free_rect_select_split_core regression: fail");
      $finish;
   end

endmodule

/* guillotine_free_rect_select_split_core.f */
+incdir+rtl/core
rtl/core/gfrss_pkg.sv
rtl/core/gfrss_req_if.sv
rtl/core/gfrss_rsp_if.sv
rtl/core/gfrss_ram.sv
rtl/core/gfrss_ctrl.sv
rtl/core/gfrss_dp.sv
rtl/core/guillotine_free_rect_select_split_core.sv
rtl/core/gfrss_chk.sv
tb/sv/guillotine_free_rect_select_split_core_tb.sv
